// ===== hw/rtl/i2ckr_pkg.sv =====
// Shared types, register codes and reset values of the two-byte key reader.
package i2ckr_pkg;

   localparam int DELAY_WIDTH_DEF = 16;

   localparam int PHASE_TICKS_W = 16;
   localparam int ADDR_W        = 8;
   localparam int TIMEOUT_W     = 8;
   localparam int BYTE_W        = 8;
   localparam int BIT_CNT_W     = 3;
   localparam int KEY_W         = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_ADDRESS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT  = 2'd2;

   localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET  = 16'd500;
   localparam logic [ADDR_W-1:0]        READ_ADDRESS_RESET = 8'd203;
   localparam logic [TIMEOUT_W-1:0]     ACK_TIMEOUT_RESET  = 8'd250;

   localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_S0, PH_S1, PH_S2,
      PH_B0, PH_B1, PH_B2,
      PH_A0, PH_A1, PH_A2, PH_A3,
      PH_R0, PH_R1,
      PH_K0, PH_K1, PH_K2,
      PH_P0, PH_P1
   } phase_type;

   typedef struct packed {
      logic start_read;
      logic sda_in;
   } req_payload_type;

   typedef struct packed {
      logic             scl_out;
      logic             sda_release;
      logic             busy_res;
      logic             done_res;
      logic             failed;
      logic [KEY_W-1:0] key_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [PHASE_TICKS_W-1:0] phase_ticks;
      logic [ADDR_W-1:0]        read_address;
      logic [TIMEOUT_W-1:0]     ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic clear;
   } timer_ctl_type;

endpackage

// ===== hw/rtl/i2ckr_stream_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
interface i2ckr_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/i2c_two_byte_key_reader.sv =====
// I2C master that reads a two-byte key word, stepped one bus tick per word.
//
// Each word on req_ch is one tick of bus timing and carries start_read and the
// sampled SDA level. For every accepted word exactly one word appears on rsp_ch
// with the SCL and SDA levels to drive for that tick, busy, a done pulse with
// its failure flag, and the last key read (second byte high, first byte low).
// A start_read while idle begins start, address byte, acknowledge poll, two
// read bytes (ACK then NACK) and stop; a missing acknowledge ends in a stop
// with failed set. Each timed bus phase lasts phase_ticks words.
// Registers are written through csr_wr_en, csr_index and csr_wr_data; the user
// must write them only while idle; the block does not enforce it. rsp_ch.valid
// rises in the cycle after acceptance; one word per cycle if rsp_ch is ready.
// When rsp_ch stalls, the held result stays put and req_ch.ready drops until
// it is taken. Reset returns the bus to idle with both lines released, clears
// the key word and loads the register reset values.
module i2c_two_byte_key_reader import i2ckr_pkg::*; #(
   parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   i2ckr_stream_if.sink           req_ch,
   i2ckr_stream_if.source         rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type         cfg_ff, cfg_in;
   rsp_payload_type result;
   req_payload_type req_word;
   logic            accept;

   assign req_word = req_ch.payload;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_TICKS:  cfg_in.phase_ticks  = csr_wr_data[PHASE_TICKS_W-1:0];
            CSR_READ_ADDRESS: cfg_in.read_address = csr_wr_data[ADDR_W-1:0];
            CSR_ACK_TIMEOUT:  cfg_in.ack_timeout  = csr_wr_data[TIMEOUT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks  <= PHASE_TICKS_RESET;
         cfg_ff.read_address <= READ_ADDRESS_RESET;
         cfg_ff.ack_timeout  <= ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2ckr_sequencer #(.DELAY_WIDTH(DELAY_WIDTH)) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .cfg    (cfg_ff),
      .result (result)
   );

   i2ckr_rsp_stage u_rsp_stage (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .result (result),
      .accept (accept)
   );

endmodule

// ===== hw/rtl/i2ckr_phase_timer.sv =====
// Tick counter that times each SCL/SDA phase of the bus sequence.
module i2ckr_phase_timer import i2ckr_pkg::*; #(
   parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  timer_ctl_type            ctl,
   input  logic [PHASE_TICKS_W-1:0] phase_ticks,
   output logic                     over
);

   localparam int LEN_W = (DELAY_WIDTH < PHASE_TICKS_W) ? DELAY_WIDTH : PHASE_TICKS_W;

   logic [DELAY_WIDTH-1:0] tick_ff, tick_in;
   logic [LEN_W-1:0]       len_raw;
   logic [DELAY_WIDTH:0]   len, tick_next;

   // Only the low min(DELAY_WIDTH, PHASE_TICKS_W) bits of the register count; zero is held as one tick.
   assign len_raw   = phase_ticks[LEN_W-1:0];
   assign len       = (len_raw == '0) ? (DELAY_WIDTH+1)'(1) : (DELAY_WIDTH+1)'(len_raw);
   assign tick_next = {1'b0, tick_ff} + 1'b1;
   assign over      = (tick_next >= len);

   always_comb begin
      tick_in = tick_ff;
      if (ctl.clear) begin
         tick_in = '0;
      end else if (ctl.step) begin
         tick_in = over ? '0 : tick_next[DELAY_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

endmodule

// ===== hw/rtl/i2ckr_sequencer.sv =====
// Bus phase state machine with the address shifter and the read data path.
module i2ckr_sequencer import i2ckr_pkg::*; #(
   parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   phase_type phase_ff, phase_in;

   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic                 byte_ff, byte_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic [BYTE_W-1:0]    first_ff, first_in;
   logic [TIMEOUT_W-1:0] wait_ff, wait_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 fail_ff, fail_in;

   logic          scl_o, sda_o, done_o, fail_o, timed, clear, over;
   timer_ctl_type timer_ctl;

   assign timer_ctl.step  = timed && accept;
   assign timer_ctl.clear = clear && accept;

   i2ckr_phase_timer #(.DELAY_WIDTH(DELAY_WIDTH)) u_timer (
      .clock       (clock),
      .reset       (reset),
      .ctl         (timer_ctl),
      .phase_ticks (cfg.phase_ticks),
      .over        (over)
   );

   // Line levels of the phase held during this word.
   always_comb begin
      timed = 1'b1;
      case (phase_ff)
         PH_IDLE: begin scl_o = 1'b1; sda_o = 1'b1; timed = 1'b0; end
         PH_S0:   begin scl_o = 1'b1; sda_o = 1'b1; end
         PH_S1:   begin scl_o = 1'b1; sda_o = 1'b0; end
         PH_S2:   begin scl_o = 1'b0; sda_o = 1'b0; end
         PH_B0:   begin scl_o = 1'b0; sda_o = shift_ff[BYTE_W-1]; end
         PH_B1:   begin scl_o = 1'b1; sda_o = shift_ff[BYTE_W-1]; end
         PH_B2:   begin scl_o = 1'b0; sda_o = shift_ff[BYTE_W-1]; end
         PH_A0:   begin scl_o = 1'b0; sda_o = 1'b1; end
         PH_A1:   begin scl_o = 1'b1; sda_o = 1'b1; end
         PH_A2:   begin scl_o = 1'b1; sda_o = 1'b1; timed = 1'b0; end
         PH_A3:   begin scl_o = 1'b0; sda_o = 1'b1; end
         PH_R0:   begin scl_o = 1'b1; sda_o = 1'b1; end
         PH_R1:   begin scl_o = 1'b0; sda_o = 1'b1; end
         PH_K0:   begin scl_o = 1'b0; sda_o = byte_ff; end
         PH_K1:   begin scl_o = 1'b1; sda_o = byte_ff; end
         PH_K2:   begin scl_o = 1'b0; sda_o = byte_ff; end
         PH_P0:   begin scl_o = 1'b1; sda_o = 1'b0; end
         PH_P1:   begin scl_o = 1'b1; sda_o = 1'b1; end
         default: begin scl_o = 1'b1; sda_o = 1'b1; timed = 1'b0; end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: if (req.start_read) phase_in = PH_S0;
         PH_S0:   if (over) phase_in = PH_S1;
         PH_S1:   if (over) phase_in = PH_S2;
         PH_S2:   if (over) phase_in = PH_B0;
         PH_B0:   if (over) phase_in = PH_B1;
         PH_B1:   if (over) phase_in = PH_B2;
         PH_B2:   if (over) phase_in = (bit_ff == LAST_BIT) ? PH_A0 : PH_B0;
         PH_A0:   if (over) phase_in = PH_A1;
         PH_A1:   if (over) phase_in = PH_A2;
         PH_A2: begin
            if (!req.sda_in) begin
               phase_in = PH_A3;
            end else if (wait_ff >= cfg.ack_timeout) begin
               phase_in = PH_P0;
            end
         end
         PH_A3:   if (over) phase_in = PH_R0;
         PH_R0:   if (over) phase_in = PH_R1;
         PH_R1:   if (over) phase_in = (bit_ff == LAST_BIT) ? PH_K0 : PH_R0;
         PH_K0:   if (over) phase_in = PH_K1;
         PH_K1:   if (over) phase_in = PH_K2;
         PH_K2:   if (over) phase_in = byte_ff ? PH_P0 : PH_R0;
         PH_P0:   if (over) phase_in = PH_P1;
         PH_P1:   if (over) phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Shifter, counters and the key word.
   always_comb begin
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      first_in = first_ff;
      wait_in  = wait_ff;
      key_in   = key_ff;
      fail_in  = fail_ff;
      clear    = 1'b0;
      done_o   = 1'b0;
      fail_o   = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req.start_read) begin
               shift_in = cfg.read_address;
               bit_in   = '0;
               byte_in  = 1'b0;
               fail_in  = 1'b0;
               wait_in  = '0;
               clear    = 1'b1;
            end
         end
         PH_B2: begin
            if (over) begin
               shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
               bit_in   = (bit_ff == LAST_BIT) ? '0 : bit_ff + 1'b1;
            end
         end
         PH_A1: begin
            if (over) wait_in = '0;
         end
         PH_A2: begin
            if (!req.sda_in) begin
               clear = 1'b1;
            end else if (wait_ff >= cfg.ack_timeout) begin
               fail_in = 1'b1;
               clear   = 1'b1;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         PH_A3: begin
            if (over) begin
               shift_in = '0;
               bit_in   = '0;
               byte_in  = 1'b0;
            end
         end
         PH_R0: begin
            // The bit is taken on the last tick of SCL high.
            if (over) shift_in = {shift_ff[BYTE_W-2:0], req.sda_in};
         end
         PH_R1: begin
            if (over) bit_in = (bit_ff == LAST_BIT) ? '0 : bit_ff + 1'b1;
         end
         PH_K2: begin
            if (over && !byte_ff) begin
               first_in = shift_ff;
               byte_in  = 1'b1;
               shift_in = '0;
            end
         end
         PH_P1: begin
            if (over) begin
               done_o = 1'b1;
               fail_o = fail_ff;
               if (!fail_ff) key_in = {shift_ff, first_ff};
            end
         end
         PH_S0, PH_S1, PH_S2, PH_B0, PH_B1, PH_A0, PH_K0, PH_K1, PH_P0: begin
            clear = 1'b0;
         end
         default: clear = 1'b1;
      endcase
   end

   assign result.scl_out     = scl_o;
   assign result.sda_release = sda_o;
   assign result.busy_res    = (phase_ff != PH_IDLE);
   assign result.done_res    = done_o;
   assign result.failed      = fail_o;
   assign result.key_value   = key_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= '0;
         byte_ff  <= 1'b0;
         shift_ff <= '0;
         first_ff <= '0;
         wait_ff  <= '0;
         key_ff   <= '0;
         fail_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         first_ff <= first_in;
         wait_ff  <= wait_in;
         key_ff   <= key_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

// ===== hw/rtl/i2ckr_rsp_stage.sv =====
// Result register and the handshake that couples the two channels.
module i2ckr_rsp_stage import i2ckr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   i2ckr_stream_if.sink          req_ch,
   i2ckr_stream_if.source        rsp_ch,
   input  rsp_payload_type       result,
   output logic                  accept
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // A new word enters when no result is held or the held one leaves in the same cycle.
   assign req_ch.ready   = !valid_ff || rsp_ch.ready;
   assign accept         = req_ch.valid && req_ch.ready;
   assign valid_in       = accept || (valid_ff && !rsp_ch.ready);
   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.payload = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= result;
      end
   end

endmodule
